FILE: rtl/qpe_pkg.sv
package qpe_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [6:0] WRAP_LIMIT_RESET = 7'd73;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] CHAR_EQ  = 8'h3D;

    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        LEAD_NONE,
        LEAD_PLAIN,
        LEAD_ESCAPE,
        LEAD_CRLF
    } lead_kind_t;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    // One queued job: the bytes caused by one input transaction
    typedef struct packed {
        lead_kind_t lead;
        logic       soft_break;
        logic [7:0] data_byte;
    } job_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'h0, v};
        end else begin
            r = 8'h37 + {4'h0, v};
        end
        return r;
    endfunction

    function automatic logic [2:0] lead_len(input lead_kind_t k);
        logic [2:0] r;
        unique case (k)
            LEAD_PLAIN:  r = 3'd1;
            LEAD_ESCAPE: r = 3'd3;
            LEAD_CRLF:   r = 3'd2;
            default:     r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/qpe_front.sv
module qpe_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  qpe_pkg::in_item_t  s_data,
    input  logic               q_full,
    output logic               push,
    output qpe_pkg::job_t      push_job
);

    logic [6:0]          wrap_limit_reg;
    logic [6:0]          wrap_limit_next;
    logic [6:0]          column_reg;
    logic [6:0]          column_next;
    logic [7:0]          col_wide;
    logic [6:0]          col_after;
    logic                soft_brk;
    logic                accept;
    qpe_pkg::lead_kind_t lead;

    always_comb begin
        lead      = qpe_pkg::LEAD_NONE;
        col_wide  = {1'b0, column_reg};
        soft_brk  = 1'b0;
        col_after = 7'd0;
        if (s_data.func == qpe_pkg::FUNC_FLUSH) begin
            if (column_reg != 7'd0) begin
                lead = qpe_pkg::LEAD_CRLF;
            end
        end else begin
            if (s_data.data_byte == qpe_pkg::CHAR_LF ||
                s_data.data_byte == qpe_pkg::CHAR_NUL) begin
                lead     = qpe_pkg::LEAD_CRLF;
                col_wide = 8'd0;
            end else if (s_data.data_byte[7] || s_data.data_byte == qpe_pkg::CHAR_DOT ||
                         s_data.data_byte == qpe_pkg::CHAR_EQ) begin
                lead     = qpe_pkg::LEAD_ESCAPE;
                col_wide = {1'b0, column_reg} + 8'd3;
            end else if (s_data.data_byte != qpe_pkg::CHAR_CR) begin
                lead     = qpe_pkg::LEAD_PLAIN;
                col_wide = {1'b0, column_reg} + 8'd1;
            end
            soft_brk  = col_wide > {1'b0, wrap_limit_reg};
            col_after = soft_brk ? 7'd0 : col_wide[6:0];
        end
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Drop transactions that produce no bytes at all
    assign push = accept && (lead != qpe_pkg::LEAD_NONE || soft_brk);

    assign push_job.lead       = lead;
    assign push_job.soft_break = soft_brk;
    assign push_job.data_byte  = s_data.data_byte;

    assign column_next     = accept ? col_after : column_reg;
    assign wrap_limit_next = cfg_we ? cfg_wdata : wrap_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg     <= 7'd0;
            wrap_limit_reg <= qpe_pkg::WRAP_LIMIT_RESET;
        end else begin
            column_reg     <= column_next;
            wrap_limit_reg <= wrap_limit_next;
        end
    end

endmodule

FILE: rtl/qpe_queue.sv
module qpe_queue #(
    parameter int DEPTH = qpe_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  qpe_pkg::job_t push_job,
    input  logic          pop,
    output qpe_pkg::job_t head_job,
    output logic          empty,
    output logic          full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    qpe_pkg::job_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign empty    = count_reg == '0;
    assign full     = count_reg == FULL_CNT;
    assign head_job = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/qpe_back.sv
module qpe_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  qpe_pkg::job_t      head_job,
    input  logic               q_empty,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output qpe_pkg::out_item_t m_data
);

    logic [2:0]         step_reg;
    logic [2:0]         step_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    qpe_pkg::out_item_t m_data_reg;
    qpe_pkg::out_item_t m_data_next;
    logic [2:0]         ll;
    logic [2:0]         total;
    logic [2:0]         tail_step;
    logic               load;
    logic               final_step;
    logic [7:0]         cur_byte;

    assign ll         = qpe_pkg::lead_len(head_job.lead);
    assign total      = ll + (head_job.soft_break ? 3'd3 : 3'd0);
    assign final_step = step_reg == (total - 3'd1);
    assign tail_step  = step_reg - ll;
    assign load       = !q_empty && (!m_valid_reg || m_ready);
    assign pop        = load && final_step;

    always_comb begin
        cur_byte = qpe_pkg::CHAR_EQ;
        if (step_reg < ll) begin
            unique case (head_job.lead)
                qpe_pkg::LEAD_PLAIN: cur_byte = head_job.data_byte;
                qpe_pkg::LEAD_ESCAPE: begin
                    if (step_reg == 3'd0) begin
                        cur_byte = qpe_pkg::CHAR_EQ;
                    end else if (step_reg == 3'd1) begin
                        cur_byte = qpe_pkg::hex_digit(head_job.data_byte[7:4]);
                    end else begin
                        cur_byte = qpe_pkg::hex_digit(head_job.data_byte[3:0]);
                    end
                end
                qpe_pkg::LEAD_CRLF: begin
                    cur_byte = (step_reg == 3'd0) ? qpe_pkg::CHAR_CR : qpe_pkg::CHAR_LF;
                end
                default: cur_byte = qpe_pkg::CHAR_EQ;
            endcase
        end else begin
            // soft break: '=' CR LF
            case (tail_step)
                3'd0:    cur_byte = qpe_pkg::CHAR_EQ;
                3'd1:    cur_byte = qpe_pkg::CHAR_CR;
                default: cur_byte = qpe_pkg::CHAR_LF;
            endcase
        end
    end

    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next         = 1'b1;
            m_data_next.out_byte = cur_byte;
            m_data_next.last     = final_step;
            step_next            = final_step ? 3'd0 : step_reg + 3'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: rtl/quoted_printable_encoder_core.sv
// Quoted-printable encoder core.
// Input channel (s_valid/s_ready/s_data): one transaction per raw byte, or an
// end-of-stream flush when s_data.func is set. Output channel (m_valid/m_ready/
// m_data): one encoded character per transaction, m_data.last marking the final
// character caused by an input transaction. Inputs that cause no character
// (a carriage return without a soft break, a flush on an empty line) are dropped.
// cfg_we/cfg_wdata write the wrap limit (reset value 73); the user must write it
// only while the core is idle, the core does not enforce it. An accepted input is
// queued; its first character then goes into the output register behind m_valid.
// Throughput: one input per cycle while the queue has room; one output character
// per cycle while m_ready is high; an input gives 1 to 6 characters, a dropped one
// none. A job queue of QUEUE_DEPTH entries sits between the classifier and the
// character sequencer; the input keeps being accepted while the queue has room,
// even when the receiver stalls. A stall holds the output register.
// Reset (aresetn, synchronous, active low) clears the column count, the queue
// and the output valid, and restores the wrap limit to 73.
module quoted_printable_encoder_core #(
    parameter int QUEUE_DEPTH = qpe_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  qpe_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output qpe_pkg::out_item_t m_data
);

    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;
    qpe_pkg::job_t push_job;
    qpe_pkg::job_t head_job;

    qpe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    qpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    qpe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty)
        else $error("job queue read while empty");

    a_cr_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.out_byte == qpe_pkg::CHAR_CR) |-> !m_data.last)
        else $error("carriage return flagged as last character");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 80;
    localparam int PREDICTED     = -1;
    localparam int MAX_CHARS     = 6;
    localparam logic [47:0] CRLF_PAIR = {32'h0, qpe_pkg::CHAR_CR, qpe_pkg::CHAR_LF};

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    // One directed row: either typed characters (first one in the highest used
    // byte) or PREDICTED to take the predictor's answer
    typedef struct {
        logic        func;
        logic [7:0]  data_byte;
        int          n_chars;
        logic [47:0] chars;
    } vec_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [6:0]         cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    qpe_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    qpe_pkg::out_item_t m_data;

    qpe_pkg::out_item_t expected_chars[$];
    int        model_column = 0;
    int        model_limit = int'(qpe_pkg::WRAP_LIMIT_RESET);
    int        burst_left = 0;
    int        errors = 0;
    int        cycle_count = 0;
    bit        hold_request = 1'b0;

    vec_row_t directed_rows [23] = '{
        '{qpe_pkg::FUNC_DATA,  8'h41,             1,         "A"},
        '{qpe_pkg::FUNC_DATA,  8'hFF,             3,         "=FF"},
        '{qpe_pkg::FUNC_DATA,  8'h80,             3,         "=80"},
        '{qpe_pkg::FUNC_DATA,  qpe_pkg::CHAR_DOT, 3,         "=2E"},
        '{qpe_pkg::FUNC_DATA,  qpe_pkg::CHAR_EQ,  3,         "=3D"},
        '{qpe_pkg::FUNC_DATA,  qpe_pkg::CHAR_CR,  0,         '0},
        '{qpe_pkg::FUNC_DATA,  qpe_pkg::CHAR_LF,  2,         CRLF_PAIR},
        '{qpe_pkg::FUNC_FLUSH, 8'h00,             0,         '0},
        '{qpe_pkg::FUNC_DATA,  8'h7A,             PREDICTED, '0},
        '{qpe_pkg::FUNC_DATA,  qpe_pkg::CHAR_NUL, 2,         CRLF_PAIR},
        '{qpe_pkg::FUNC_DATA,  8'h7F,             PREDICTED, '0},
        '{qpe_pkg::FUNC_FLUSH, 8'hFF,             2,         CRLF_PAIR},
        '{qpe_pkg::FUNC_DATA,  8'h20,             PREDICTED, '0},
        '{qpe_pkg::FUNC_DATA,  8'h2D,             PREDICTED, '0},
        '{qpe_pkg::FUNC_DATA,  8'h2F,             PREDICTED, '0},
        '{qpe_pkg::FUNC_DATA,  8'h3C,             PREDICTED, '0},
        '{qpe_pkg::FUNC_DATA,  8'h3E,             PREDICTED, '0},
        '{qpe_pkg::FUNC_DATA,  8'h01,             PREDICTED, '0},
        '{qpe_pkg::FUNC_DATA,  8'hC3,             3,         "=C3"},
        '{qpe_pkg::FUNC_DATA,  qpe_pkg::CHAR_CR,  0,         '0},
        '{qpe_pkg::FUNC_FLUSH, 8'h00,             2,         CRLF_PAIR},
        '{qpe_pkg::FUNC_DATA,  qpe_pkg::CHAR_CR,  0,         '0},
        '{qpe_pkg::FUNC_FLUSH, 8'h5A,             0,         '0}
    };

    // Random phases: wrap limit, item count, line-end share, escape share
    int phase_limit [5]   = '{0, 127, 4, 120, 64};
    int phase_items [5]   = '{12, 32, 15, 15, 13};
    int phase_breaks [5]  = '{8, 0, 8, 5, 8};
    int phase_escapes [5] = '{45, 85, 45, 45, 45};

    quoted_printable_encoder_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + v : 8'h41 + (v - 4'd10);
    endfunction

    // Encode one input transaction and advance the column count
    function automatic int encode_item(input qpe_pkg::in_item_t item,
                                       output qpe_pkg::out_item_t chars [MAX_CHARS]);
        logic [7:0] seq [MAX_CHARS];
        int n;
        int col;
        n = 0;
        col = model_column;
        if (item.func == qpe_pkg::FUNC_FLUSH) begin
            if (col > 0) begin
                seq[0] = qpe_pkg::CHAR_CR;
                seq[1] = qpe_pkg::CHAR_LF;
                n = 2;
            end
            model_column = 0;
        end else begin
            if (item.data_byte == qpe_pkg::CHAR_LF || item.data_byte == qpe_pkg::CHAR_NUL) begin
                seq[0] = qpe_pkg::CHAR_CR;
                seq[1] = qpe_pkg::CHAR_LF;
                n = 2;
                col = 0;
            end else if (item.data_byte[7] || item.data_byte == qpe_pkg::CHAR_DOT ||
                         item.data_byte == qpe_pkg::CHAR_EQ) begin
                seq[0] = qpe_pkg::CHAR_EQ;
                seq[1] = nibble_char(item.data_byte[7:4]);
                seq[2] = nibble_char(item.data_byte[3:0]);
                n = 3;
                col += 3;
            end else if (item.data_byte != qpe_pkg::CHAR_CR) begin
                seq[0] = item.data_byte;
                n = 1;
                col += 1;
            end
            // soft line break
            if (col > model_limit) begin
                seq[n]     = qpe_pkg::CHAR_EQ;
                seq[n + 1] = qpe_pkg::CHAR_CR;
                seq[n + 2] = qpe_pkg::CHAR_LF;
                n += 3;
                col = 0;
            end
            model_column = col % 128;
        end
        for (int k = 0; k < n; k++) begin
            chars[k] = '{out_byte: seq[k], last: (k == n - 1)};
        end
        return n;
    endfunction

    function automatic qpe_pkg::in_item_t pick_item(input int break_pct, input int esc_pct);
        qpe_pkg::in_item_t item;
        int roll;
        item.func = qpe_pkg::FUNC_DATA;
        item.data_byte = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < break_pct) begin
            item.data_byte = ($urandom_range(0, 1) == 1) ? qpe_pkg::CHAR_LF : qpe_pkg::CHAR_NUL;
        end else if (roll < 2 * break_pct) begin
            item.func = qpe_pkg::FUNC_FLUSH;
        end else if (roll < 2 * break_pct + 5) begin
            item.data_byte = qpe_pkg::CHAR_CR;
        end else if (roll < esc_pct) begin
            case ($urandom_range(0, 3))
                0: item.data_byte = qpe_pkg::CHAR_DOT;
                1: item.data_byte = qpe_pkg::CHAR_EQ;
                default: item.data_byte[7] = 1'b1;
            endcase
        end else if (roll >= esc_pct + 15) begin
            item.data_byte = 8'($urandom_range(32'h20, 32'h7E));
        end
        return item;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 50) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        errors++;
    endtask

    // Offer one transaction in bursts with random gaps; queue its characters once accepted
    task automatic send_item(input qpe_pkg::in_item_t item, input int n_typed,
                             input logic [47:0] typed);
        qpe_pkg::out_item_t chars [MAX_CHARS];
        int n;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        n = encode_item(item, chars);
        if (n_typed == PREDICTED) begin
            for (int k = 0; k < n; k++) begin
                expected_chars.push_back(chars[k]);
            end
        end else begin
            for (int k = 0; k < n_typed; k++) begin
                expected_chars.push_back('{out_byte: typed[8 * (n_typed - 1 - k) +: 8],
                                           last: (k == n_typed - 1)});
            end
        end
    endtask

    // Drain, let dropped transactions settle, then write the wrap limit
    task automatic set_wrap_limit(input int value);
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 7'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        model_limit = value;
    endtask

    initial begin : stimulus
        qpe_pkg::in_item_t item;
        phase_limit[4] = $urandom_range(5, 119);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i]) begin
            item.func      = directed_rows[i].func;
            item.data_byte = directed_rows[i].data_byte;
            send_item(item, directed_rows[i].n_chars, directed_rows[i].chars);
        end
        foreach (phase_limit[p]) begin
            set_wrap_limit(phase_limit[p]);
            // hold the receiver off during the long phase so the queue fills
            if (p == 1) begin
                hold_request = 1'b1;
            end
            repeat (phase_items[p]) begin
                send_item(pick_item(phase_breaks[p], phase_escapes[p]), PREDICTED, '0);
            end
        end
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : receiver
        rx_mode_t mode;
        int mode_left;
        int hold_left;
        mode = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 40);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: m_ready <= (mode_left % 4 == 0);
                    default:   m_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        qpe_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character %h last %b",
                                          m_data.out_byte, m_data.last));
            end else begin
                want = expected_chars.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    report_mismatch($sformatf("character %h, want %h",
                                              m_data.out_byte, want.out_byte));
                end
                if (m_data.last !== want.last) begin
                    report_mismatch($sformatf("last %b on character %h, want %b",
                                              m_data.last, m_data.out_byte, want.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

FILE: files.f
rtl/qpe_pkg.sv
rtl/qpe_front.sv
rtl/qpe_queue.sv
rtl/qpe_back.sv
rtl/quoted_printable_encoder_core.sv
test/tb_top.sv
